// ===== hdl/pid_pkg.sv =====
// shared types, constants and clamp helper for the q8.8 pid controller
// no dependencies; imported by pid_front, pid_back and the top level
`default_nettype none

package pid_pkg;

    localparam int DATA_W    = 16;
    localparam int INTEG_W   = 24;
    localparam int FRAC_BITS = 8;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int WIDE_W    = 36;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RAIL_LOW     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RAIL_HIGH    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MANUAL_MODE  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MANUAL_VALUE = 3'd6;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef logic signed [DATA_W-1:0]  sample_t;
    typedef logic signed [INTEG_W-1:0] integ_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;

    typedef struct packed {
        sample_t prop_gain;
        sample_t integ_gain;
        sample_t deriv_gain;
        sample_t rail_low;
        sample_t rail_high;
        logic    manual_mode;
        sample_t manual_value;
    } cfg_t;

    typedef struct packed {
        logic    clear;
        sample_t err;
        sample_t dmeas;
    } cmd_t;

    // lower bound first, then upper bound
    function automatic wide_t clamp_wide(wide_t v, wide_t lo, wide_t hi);
        wide_t r;
        r = (v < lo) ? lo : v;
        r = (r > hi) ? hi : r;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pid_fifo.sv =====
// small register-based queue used for command and result beats
// depends on nothing but its parameters
`default_nettype none

module pid_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pid_front.sv =====
// front end: accepts beats, forms wrapped error and measurement delta
// depends on pid_pkg; feeds the command queue
`default_nettype none

module pid_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              opcode,
    input  pid_pkg::sample_t  setpoint,
    input  pid_pkg::sample_t  measurement,
    input  logic              cmd_full,
    output logic              cmd_push,
    output pid_pkg::cmd_t     cmd_data
);

    import pid_pkg::*;

    logic    history_reg, history_next;
    sample_t last_meas_reg, last_meas_next;
    sample_t err;
    sample_t dmeas;
    logic    is_clear;

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full;
    assign is_clear = (opcode == OP_CLEAR);

    always_comb
    begin
        err   = setpoint - measurement;
        dmeas = history_reg ? sample_t'(measurement - last_meas_reg) : sample_t'(0);
        cmd_data.clear = is_clear;
        cmd_data.err   = err;
        cmd_data.dmeas = dmeas;

        history_next   = history_reg;
        last_meas_next = last_meas_reg;
        if (cmd_push)
        begin
            if (is_clear)
            begin
                history_next = 1'b0;
            end
            else
            begin
                history_next   = 1'b1;
                last_meas_next = measurement;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg   <= 1'b0;
            last_meas_reg <= '0;
        end
        else
        begin
            history_reg   <= history_next;
            last_meas_reg <= last_meas_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pid_back.sv =====
// back end: gain products, integrator with anti-windup, drive clamp
// depends on pid_pkg; drains the command queue, fills the result queue
`default_nettype none

module pid_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pid_pkg::cfg_t     cfg,
    input  logic              cmd_empty,
    input  pid_pkg::cmd_t     cmd_data,
    output logic              cmd_pop,
    input  logic              res_full,
    output logic              res_push,
    output pid_pkg::sample_t  res_drive
);

    import pid_pkg::*;

    // stage 1: products
    logic    s1_valid_reg;
    logic    s1_clear_reg;
    prod_t   s1_p_reg;
    prod_t   s1_d_reg;
    prod_t   s1_ie_reg;
    sample_t s1_mdrive_reg;

    // stage 2: integrator and partial sum
    logic    s2_valid_reg;
    logic    s2_clear_reg;
    logic    s2_manual_reg;
    wide_t   s2_pd_reg;
    sample_t s2_mdrive_reg;
    integ_t  integ_reg, integ_next;
    logic    skip_reg, skip_next;

    logic    stall;
    logic    adv;
    sample_t in_err;
    sample_t in_dmeas;
    prod_t   p_prod;
    prod_t   d_prod;
    prod_t   ie_prod;
    wide_t   mdrive_w;
    wide_t   ilo;
    wide_t   ihi;
    wide_t   acc;
    wide_t   man_integ;
    wide_t   out_sum;
    wide_t   out_shift;
    wide_t   auto_drive;

    assign stall   = s2_valid_reg && !s2_clear_reg && res_full;
    assign adv     = !stall;
    assign cmd_pop = adv && !cmd_empty;

    assign in_err   = cmd_data.err;
    assign in_dmeas = cmd_data.dmeas;
    assign p_prod   = cfg.prop_gain * in_err;
    assign d_prod   = cfg.deriv_gain * in_dmeas;
    assign ie_prod  = cfg.integ_gain * in_err;
    assign mdrive_w = clamp_wide(wide_t'(cfg.manual_value), wide_t'(cfg.rail_low),
                                 wide_t'(cfg.rail_high));

    assign ilo = wide_t'(cfg.rail_low) <<< FRAC_BITS;
    assign ihi = wide_t'(cfg.rail_high) <<< FRAC_BITS;

    always_comb
    begin
        acc        = wide_t'(integ_reg) + (skip_reg ? wide_t'(0) : wide_t'(s1_ie_reg));
        man_integ  = (wide_t'(s1_mdrive_reg) <<< FRAC_BITS) - wide_t'(s1_p_reg)
                     - wide_t'(s1_d_reg);
        integ_next = integ_reg;
        skip_next  = skip_reg;
        if (adv && s1_valid_reg)
        begin
            if (s1_clear_reg)
            begin
                integ_next = '0;
                skip_next  = 1'b0;
            end
            else if (cfg.manual_mode)
            begin
                integ_next = integ_t'(clamp_wide(man_integ, ilo, ihi));
                skip_next  = 1'b1;
            end
            else
            begin
                integ_next = integ_t'(clamp_wide(acc, ilo, ihi));
                skip_next  = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_sum    = s2_pd_reg + wide_t'(integ_reg);
        out_shift  = out_sum >>> FRAC_BITS;
        auto_drive = clamp_wide(out_shift, wide_t'(cfg.rail_low), wide_t'(cfg.rail_high));
        res_drive  = s2_manual_reg ? s2_mdrive_reg : sample_t'(auto_drive);
    end

    assign res_push = s2_valid_reg && !s2_clear_reg && !res_full;

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            s1_clear_reg  <= cmd_data.clear;
            s1_p_reg      <= p_prod;
            s1_d_reg      <= -d_prod;
            s1_ie_reg     <= ie_prod;
            s1_mdrive_reg <= sample_t'(mdrive_w);
        end
        if (adv && s1_valid_reg)
        begin
            s2_clear_reg  <= s1_clear_reg;
            s2_manual_reg <= cfg.manual_mode;
            s2_pd_reg     <= wide_t'(s1_p_reg) + wide_t'(s1_d_reg);
            s2_mdrive_reg <= s1_mdrive_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            integ_reg    <= '0;
            skip_reg     <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= cmd_pop;
                s2_valid_reg <= s1_valid_reg;
            end
            integ_reg <= integ_next;
            skip_reg  <= skip_next;
        end
    end

`ifndef SYNTHESIS
    a_stall_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> !cmd_pop)
        else $error("command beat taken while back end stalled");

    a_push_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (s2_valid_reg && !s2_clear_reg))
        else $error("result beat without a control step");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_valid_reg && s1_clear_reg) |=> (integ_reg == '0 && !skip_reg))
        else $error("clear did not zero integrator");

    a_manual_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_valid_reg && !s1_clear_reg && cfg.manual_mode) |=> skip_reg)
        else $error("manual step did not arm integral skip");
`endif

endmodule

`default_nettype wire

// ===== hdl/fixed_point_pid_controller.sv =====
// path: a step beat passes through the command queue, stage 1, stage 2 and the result queue to the result ports
// throughput: one beat per cycle while the result queue is not full, set by the integrator update loop
// clear beats take a slot in the pipeline but give no result
// reset: registers return to defaults, integrator and history clear, queues empty
// top level: configuration registers, front end, command queue, back end, result queue
// depends on pid_pkg, pid_front, pid_fifo, pid_back
`default_nettype none

module fixed_point_pid_controller #(
    parameter int CMD_DEPTH = pid_pkg::CMD_DEPTH,
    parameter int RES_DEPTH = pid_pkg::RES_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pid_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  logic                        opcode,
    input  pid_pkg::sample_t            setpoint,
    input  pid_pkg::sample_t            measurement,
    output logic                        empty,
    input  logic                        pop,
    output pid_pkg::sample_t            drive
);

    import pid_pkg::*;

    localparam int CMD_W = $bits(cmd_t);

    cfg_t                    cfg_reg, cfg_next;
    logic                    cfg_wr;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic                    cmd_full;
    logic                    cmd_push;
    cmd_t                    cmd_wdata;
    logic [CMD_W-1:0]        cmd_rbits;
    cmd_t                    cmd_rdata;
    logic                    cmd_empty;
    logic                    cmd_pop;
    logic                    res_full;
    logic                    res_push;
    sample_t                 res_drive;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_PROP_GAIN:    cfg_next.prop_gain    = pwdata[DATA_W-1:0];
                REG_INTEG_GAIN:   cfg_next.integ_gain   = pwdata[DATA_W-1:0];
                REG_DERIV_GAIN:   cfg_next.deriv_gain   = pwdata[DATA_W-1:0];
                REG_RAIL_LOW:     cfg_next.rail_low     = pwdata[DATA_W-1:0];
                REG_RAIL_HIGH:    cfg_next.rail_high    = pwdata[DATA_W-1:0];
                REG_MANUAL_MODE:  cfg_next.manual_mode  = pwdata[0];
                REG_MANUAL_VALUE: cfg_next.manual_value = pwdata[DATA_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PROP_GAIN:    prdata = {16'b0, cfg_reg.prop_gain};
            REG_INTEG_GAIN:   prdata = {16'b0, cfg_reg.integ_gain};
            REG_DERIV_GAIN:   prdata = {16'b0, cfg_reg.deriv_gain};
            REG_RAIL_LOW:     prdata = {16'b0, cfg_reg.rail_low};
            REG_RAIL_HIGH:    prdata = {16'b0, cfg_reg.rail_high};
            REG_MANUAL_MODE:  prdata = {31'b0, cfg_reg.manual_mode};
            REG_MANUAL_VALUE: prdata = {16'b0, cfg_reg.manual_value};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain    <= '0;
            cfg_reg.integ_gain   <= '0;
            cfg_reg.deriv_gain   <= '0;
            cfg_reg.rail_low     <= 16'sh8000;
            cfg_reg.rail_high    <= 16'sh7fff;
            cfg_reg.manual_mode  <= 1'b0;
            cfg_reg.manual_value <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pid_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .setpoint    (setpoint),
        .measurement (measurement),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd_data    (cmd_wdata)
    );

    pid_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rbits),
        .empty (cmd_empty)
    );

    assign cmd_rdata = cmd_t'(cmd_rbits);

    pid_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_rdata),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_drive (res_drive)
    );

    pid_fifo #(
        .WIDTH (DATA_W),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_drive),
        .full  (res_full),
        .pop   (pop),
        .rdata (drive),
        .empty (empty)
    );

endmodule

`default_nettype wire

// ===== test/tb_fixed_point_pid_controller.sv =====
// self-checking testbench for the q8.8 pid controller: directed and random control beats
// checked against an in-bench model of the integrator, history and rail clamps
// depends on pid_pkg and fixed_point_pid_controller
module tb_fixed_point_pid_controller;
    import pid_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                push = 1'b0;
    logic                full;
    logic                opcode = OP_STEP;
    sample_t             setpoint = '0;
    sample_t             measurement = '0;
    logic                empty;
    logic                pop = 1'b0;
    sample_t             drive;

    fixed_point_pid_controller dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .setpoint    (setpoint),
        .measurement (measurement),
        .empty       (empty),
        .pop         (pop),
        .drive       (drive)
    );

    always #10 clk = ~clk;

    // controller model state and register copies
    sample_t c_kp = '0;
    sample_t c_ki = '0;
    sample_t c_kd = '0;
    sample_t c_lo = -16'sd32768;
    sample_t c_hi = 16'sd32767;
    logic    c_man = 1'b0;
    sample_t c_mval = '0;
    longint  m_integ = 0;
    sample_t m_last = '0;
    logic    m_hist = 1'b0;
    logic    m_skip = 1'b0;

    sample_t pending_drive[$];
    sample_t want;
    logic    gaps_on = 1'b1;
    int      n_errors = 0;
    int      n_checked = 0;
    int      n_steps = 0;
    int      n_clears = 0;
    int      n_writes = 0;

    task automatic report_mismatch(string msg);
        n_errors++;
        if (n_errors <= 200)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return v;
    endfunction

    task automatic pid_step_model(logic op, sample_t sp, sample_t meas);
        sample_t err;
        sample_t dmeas;
        longint  p;
        longint  d;
        longint  ilo;
        longint  ihi;
        longint  acc;
        longint  out;
        if (op == OP_CLEAR)
        begin
            m_integ = 0;
            m_hist = 1'b0;
            m_skip = 1'b0;
            return;
        end
        err = sp - meas;
        dmeas = '0;
        if (m_hist)
            dmeas = meas - m_last;
        m_hist = 1'b1;
        m_last = meas;
        p = longint'(c_kp) * longint'(err);
        d = -(longint'(c_kd) * longint'(dmeas));
        ilo = longint'(c_lo) * 256;
        ihi = longint'(c_hi) * 256;
        if (c_man)
        begin
            out = clip(longint'(c_mval), longint'(c_lo), longint'(c_hi));
            m_integ = clip(out * 256 - p - d, ilo, ihi);
            m_skip = 1'b1;
        end
        else
        begin
            acc = m_integ;
            if (!m_skip)
                acc = acc + longint'(c_ki) * longint'(err);
            m_skip = 1'b0;
            m_integ = clip(acc, ilo, ihi);
            out = (p + m_integ + d) >>> 8;
            out = clip(out, longint'(c_lo), longint'(c_hi));
        end
        pending_drive.push_back(sample_t'(out));
    endtask

    // result side: random back-pressure, compare each popped beat
    initial
    begin
        forever
        begin
            @(negedge clk);
            pop = gaps_on ? ($urandom_range(99) >= 28) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_drive.size() == 0)
                report_mismatch($sformatf("drive %0d with no result pending", drive));
            else
            begin
                want = pending_drive.pop_front();
                n_checked++;
                if (drive !== want)
                    report_mismatch($sformatf("drive %0d, model %0d", drive, want));
            end
        end
    end

    task automatic send_beat(logic op, sample_t sp, sample_t meas);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 28)
        begin
            push = 1'b0;
            opcode = 1'($urandom);
            setpoint = sample_t'($urandom);
            measurement = sample_t'($urandom);
            @(negedge clk);
        end
        push = 1'b1;
        opcode = op;
        setpoint = sp;
        measurement = meas;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
            @(negedge clk);
        end
        pid_step_model(op, sp, meas);
        if (op == OP_CLEAR)
            n_clears++;
        else
            n_steps++;
    endtask

    task automatic settle();
        @(negedge clk);
        push = 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, sample_t value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = {{16{value[15]}}, value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_PROP_GAIN:    c_kp = value;
            REG_INTEG_GAIN:   c_ki = value;
            REG_DERIV_GAIN:   c_kd = value;
            REG_RAIL_LOW:     c_lo = value;
            REG_RAIL_HIGH:    c_hi = value;
            REG_MANUAL_MODE:  c_man = value[0];
            REG_MANUAL_VALUE: c_mval = value;
            default: ;
        endcase
        n_writes++;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic configure(sample_t kp, sample_t ki, sample_t kd, sample_t lo, sample_t hi,
                             logic man, sample_t mval);
        settle();
        apb_write(REG_PROP_GAIN, kp);
        apb_write(REG_INTEG_GAIN, ki);
        apb_write(REG_DERIV_GAIN, kd);
        apb_write(REG_RAIL_LOW, lo);
        apb_write(REG_RAIL_HIGH, hi);
        apb_write(REG_MANUAL_MODE, sample_t'(man));
        apb_write(REG_MANUAL_VALUE, mval);
    endtask

    function automatic sample_t rand_gain(logic wide_range);
        sample_t g;
        g = sample_t'($urandom);
        if (!wide_range)
            g = sample_t'($urandom_range(0, 2047)) - 16'sd1024;
        return g;
    endfunction

    task automatic test_defaults();
        send_beat(OP_STEP, 16'sd1000, -16'sd1000);
        send_beat(OP_STEP, -16'sd32768, 16'sd32767);
    endtask

    // first step, error and delta wrap, clear then history restart
    task automatic test_history();
        configure(16'sd256, 16'sd16, 16'sd128, -16'sd32768, 16'sd32767, 1'b0, 16'sd0);
        send_beat(OP_STEP, 16'sd100, 16'sd0);
        send_beat(OP_STEP, 16'sd100, 16'sd50);
        send_beat(OP_STEP, 16'sd32767, -16'sd32768);
        send_beat(OP_STEP, -16'sd32768, 16'sd32767);
        send_beat(OP_CLEAR, 16'sd0, 16'sd0);
        send_beat(OP_STEP, 16'sd0, 16'sd1000);
        send_beat(OP_STEP, 16'sd0, -16'sd32768);
    endtask

    task automatic test_rails();
        configure(16'sd2560, 16'sd512, 16'sd0, -16'sd100, 16'sd100, 1'b0, 16'sd0);
        send_beat(OP_STEP, 16'sd30000, -16'sd30000);
        send_beat(OP_STEP, -16'sd30000, 16'sd30000);
        // lower rail above upper rail
        configure(16'sd256, 16'sd256, 16'sd256, 16'sd50, -16'sd50, 1'b0, 16'sd0);
        send_beat(OP_STEP, 16'sd10, 16'sd20);
        send_beat(OP_STEP, -16'sd5000, 16'sd20);
    endtask

    // manual output, integrator back-calculation and bumpless return
    task automatic test_manual();
        configure(16'sd512, 16'sd64, 16'sd256, -16'sd1000, 16'sd1000, 1'b1, 16'sd5000);
        send_beat(OP_STEP, 16'sd300, 16'sd100);
        send_beat(OP_STEP, 16'sd300, 16'sd150);
        configure(16'sd512, 16'sd64, 16'sd256, -16'sd1000, 16'sd1000, 1'b1, -16'sd32768);
        send_beat(OP_STEP, 16'sd300, 16'sd200);
        configure(16'sd512, 16'sd64, 16'sd256, -16'sd1000, 16'sd1000, 1'b0, -16'sd32768);
        send_beat(OP_STEP, 16'sd300, 16'sd220);
        send_beat(OP_STEP, 16'sd300, 16'sd230);
    endtask

    task automatic test_extreme_gains();
        configure(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b0, 16'sd0);
        send_beat(OP_STEP, 16'sd32767, -16'sd32768);
        send_beat(OP_STEP, -16'sd32768, 16'sd32767);
        configure(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b1,
                  16'sd32767);
        send_beat(OP_STEP, -16'sd32768, -16'sd32768);
        send_beat(OP_STEP, 16'sd32767, 16'sd32767);
    endtask

    task automatic test_random_phases();
        sample_t sp;
        sample_t meas;
        sample_t a;
        sample_t b;
        int      r;
        for (int phase = 0; phase < 10; phase++)
        begin
            a = sample_t'($urandom);
            b = sample_t'($urandom);
            if (a > b)
            begin
                sp = a;
                a = b;
                b = sp;
            end
            case (phase)
                0: configure(16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767,
                             1'b0, 16'sd0);
                1: configure(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767,
                             1'b0, 16'sd0);
                2: configure(rand_gain(1'b0), rand_gain(1'b0), rand_gain(1'b0), b, a, 1'b0,
                             16'sd0);
                4: configure(rand_gain(1'b0), rand_gain(1'b0), rand_gain(1'b0), a, b, 1'b1,
                             sample_t'($urandom));
                6: configure(rand_gain(1'b1), rand_gain(1'b1), rand_gain(1'b1), a, b, 1'b1,
                             sample_t'($urandom));
                8: configure(rand_gain(1'b1), rand_gain(1'b1), rand_gain(1'b1), -16'sd32768,
                             16'sd32767, 1'b0, 16'sd0);
                default: configure(rand_gain(1'b0), rand_gain(1'b0), rand_gain(1'b0), a, b,
                                   1'b0, sample_t'($urandom));
            endcase
            gaps_on = (phase != 3);
            sp = sample_t'($urandom);
            meas = sp;
            for (int i = 0; i < 70; i++)
            begin
                r = $urandom_range(99);
                if (r < 6)
                    send_beat(OP_CLEAR, sample_t'($urandom), sample_t'($urandom));
                else if (r < 35)
                begin
                    sp = sample_t'($urandom);
                    meas = sample_t'($urandom);
                    send_beat(OP_STEP, sp, meas);
                end
                else
                begin
                    if (r < 40)
                        sp = sp + sample_t'($urandom_range(0, 4095)) - 16'sd2048;
                    meas = meas + sample_t'($urandom_range(0, 511)) - 16'sd256;
                    send_beat(OP_STEP, sp, meas);
                end
                if (phase == 5 && i == 35)
                    settle();
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        int waited;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_defaults();
        test_history();
        test_rails();
        test_manual();
        test_extreme_gains();
        test_random_phases();
        @(negedge clk);
        push = 1'b0;
        waited = 0;
        while (pending_drive.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (pending_drive.size() != 0)
            report_mismatch($sformatf("%0d drive results never arrived", pending_drive.size()));
        $display("ran %0d control steps and %0d clears across %0d register writes",
                 n_steps, n_clears, n_writes);
        $display("compared %0d drive beats, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout waiting for the controller");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
